[rtl/tse_pkg.sv]
// Shared constants and types for the token hash sparse encoder.
// Used by the tokenizer, the remainder pipeline and the top level.
package tse_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam int unsigned VOCAB_SIZE_DEF = 30522;

	localparam int unsigned TERM_ID_W = 15;
	localparam int unsigned WEIGHT_W = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	typedef struct packed {
		logic [31:0]         hash;
		logic [WEIGHT_W-1:0] length;
		logic                term;
		logic                eot;
	} tse_token_t;

endpackage

[rtl/tse_if.sv]
// Stream interfaces for the token hash sparse encoder: text bytes in, terms out.
// Depends on nothing; the widths follow the field definitions of the block.
interface tse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source(output valid, text_byte, last_byte, input ready);
	modport sink(input valid, text_byte, last_byte, output ready);
endinterface

interface tse_term_if;
	logic        valid;
	logic        ready;
	logic [14:0] term_id;
	logic [15:0] token_weight;
	logic        term_valid;
	logic        end_of_text;

	modport source(output valid, term_id, token_weight, term_valid, end_of_text, input ready);
	modport sink(input valid, term_id, token_weight, term_valid, end_of_text, output ready);
endinterface

[rtl/tse_tokenizer.sv]
// Input register, token state and FNV-1a hash update; emits finished tokens.
// Depends on tse_pkg and tse_byte_if.
module tse_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	tse_byte_if.sink            text,
	output logic                tok_valid,
	input  logic                tok_ready,
	output tse_pkg::tse_token_t tok
);
	import tse_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] hash_q;
	logic [WEIGHT_W-1:0] len_q;
	logic        inside_q;

	logic        adv;
	logic        word;
	logic        upper;
	logic [7:0]  lower_byte;
	logic [31:0] base_hash;
	logic [31:0] new_hash;
	logic [WEIGHT_W-1:0] base_len;
	logic [WEIGHT_W-1:0] new_len;
	logic        emit;
	tse_token_t  result;

	assign adv        = !tok_valid || tok_ready;
	assign text.ready = !v_s1 || adv;

	always_comb begin
		word  = byte_s1 inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
		upper = byte_s1 inside {[8'h41:8'h5A]};
		lower_byte = upper ? (byte_s1 | 8'h20) : byte_s1;
		base_hash  = inside_q ? hash_q : FNV_BASIS;
		base_len   = inside_q ? len_q : '0;
		new_hash   = (base_hash ^ {24'd0, lower_byte}) * FNV_PRIME;
		new_len    = (base_len == WEIGHT_MAX) ? base_len : base_len + 1'b1;
	end

	always_comb begin
		emit          = 1'b0;
		result.hash   = hash_q;
		result.length = len_q;
		result.term   = 1'b0;
		result.eot    = last_s1;
		if (word) begin
			emit          = last_s1;
			result.hash   = new_hash;
			result.length = new_len;
			result.term   = 1'b1;
		end else if (inside_q) begin
			emit        = 1'b1;
			result.term = 1'b1;
		end else begin
			emit          = last_s1;
			result.length = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= FNV_BASIS;
			len_q    <= '0;
			inside_q <= 1'b0;
		end else if (v_s1 && adv) begin
			if (word && !last_s1) begin
				hash_q   <= new_hash;
				len_q    <= new_len;
				inside_q <= 1'b1;
			end else if (emit) begin
				hash_q   <= FNV_BASIS;
				len_q    <= '0;
				inside_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
		end else if (adv) begin
			tok_valid <= v_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && emit) begin
			tok <= result;
		end
	end

endmodule

[rtl/tse_mod_reduce.sv]
// Three-stage pipeline that reduces a token hash modulo the vocabulary size
// by reciprocal multiplication and one correction. Depends on tse_pkg and tse_term_if.
module tse_mod_reduce #(
	parameter int unsigned VOCAB_SIZE = tse_pkg::VOCAB_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_ready,
	input  tse_pkg::tse_token_t tok,
	tse_term_if.source          terms
);
	import tse_pkg::*;

	localparam int unsigned LOG_V = $clog2(VOCAB_SIZE);
	localparam int unsigned SHIFT = 32 + LOG_V;
	localparam int unsigned QW = 33 - LOG_V;
	localparam int unsigned RW = LOG_V + 1;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(VOCAB_SIZE);
	localparam logic [32:0] RECIP = RECIP_FULL[32:0];
	localparam logic [RW-1:0] VOCAB_R = RW'(VOCAB_SIZE);
	localparam logic [31:0] VOCAB_32 = 32'(VOCAB_SIZE);

	logic          v_s3;
	logic [QW-1:0] q_s3;
	logic [31:0]   hash_s3;
	logic [WEIGHT_W-1:0] len_s3;
	logic          term_s3;
	logic          eot_s3;

	logic          v_s4;
	logic [RW-1:0] r_s4;
	logic [WEIGHT_W-1:0] len_s4;
	logic          term_s4;
	logic          eot_s4;

	logic          en_out;
	logic          en_s4;
	logic [64:0]   prod;
	logic [31:0]   qv;
	logic [31:0]   r_full;
	logic [RW-1:0] rem;
	logic [RW+TERM_ID_W-1:0] rem_ext;

	assign en_out    = !terms.valid || terms.ready;
	assign en_s4     = !v_s4 || en_out;
	assign tok_ready = !v_s3 || en_s4;

	assign prod    = 65'(tok.hash) * 65'(RECIP);
	assign qv      = 32'(q_s3) * VOCAB_32;
	assign r_full  = hash_s3 - qv;
	assign rem     = (r_s4 >= VOCAB_R) ? r_s4 - VOCAB_R : r_s4;
	assign rem_ext = (RW + TERM_ID_W)'(rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			terms.valid <= 1'b0;
		end else begin
			if (tok_ready) begin
				v_s3 <= tok_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				terms.valid <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_ready && tok_valid) begin
			q_s3    <= prod[SHIFT +: QW];
			hash_s3 <= tok.hash;
			len_s3  <= tok.length;
			term_s3 <= tok.term;
			eot_s3  <= tok.eot;
		end
		if (en_s4 && v_s3) begin
			r_s4    <= r_full[RW-1:0];
			len_s4  <= len_s3;
			term_s4 <= term_s3;
			eot_s4  <= eot_s3;
		end
		if (en_out && v_s4) begin
			terms.term_id      <= term_s4 ? rem_ext[TERM_ID_W-1:0] : '0;
			terms.token_weight <= term_s4 ? len_s4 : '0;
			terms.term_valid   <= term_s4;
			terms.end_of_text  <= eot_s4;
		end
	end

endmodule

[rtl/token_hash_sparse_encoder.sv]
// Top level of the token hash sparse encoder: tokenizer followed by the remainder pipeline.
// Depends on tse_pkg, tse_if, tse_tokenizer and tse_mod_reduce.
//
// Usage:
// - text (tse_byte_if sink) takes one byte of text per transfer, with last_byte set
//   on the final byte. Letters and digits build tokens; any other byte ends one.
// - terms (tse_term_if source) gives one transfer per finished token, and one of its own
//   for a text that ends outside a token; term_valid tells whether a transfer carries a term.
// - A result passes the input byte register, the token register, the quotient and
//   remainder registers and the output register. One byte is taken per cycle unless
//   the output stalls, as the hash register folds one byte per clock in one constant multiply.
// - The hash remainder takes three pipeline stages: a reciprocal multiply, a multiply
//   and subtract, and one compare and subtract.
// - Reset clears the token state and all stage valid flags; no result is pending after it.
// - When the receiver stalls, the output register holds its result and the earlier
//   stages keep filling; text.ready falls only once every stage holds an item.
module token_hash_sparse_encoder #(
	parameter int unsigned VOCAB_SIZE = tse_pkg::VOCAB_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tse_byte_if.sink   text,
	tse_term_if.source terms
);
	import tse_pkg::*;

	logic       tok_valid;
	logic       tok_ready;
	tse_token_t tok;

	tse_tokenizer u_tokenizer (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	tse_mod_reduce #(
		.VOCAB_SIZE (VOCAB_SIZE)
	) u_mod_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.terms     (terms)
	);

endmodule

[rtl/tse_checker.sv]
// Port-level checks on the term output of the token hash sparse encoder.
// Bound to token_hash_sparse_encoder; depends on nothing else.
module tse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [14:0] term_id,
	input logic [15:0] token_weight,
	input logic        term_valid,
	input logic        end_of_text
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(term_id) && $stable(token_weight) &&
			$stable(term_valid) && $stable(end_of_text))
		else $error("result changed while stalled");

	// A result without a term only closes a text and carries zeros.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !term_valid |-> end_of_text && term_id == 15'd0 && token_weight == 16'd0)
		else $error("empty result outside end of text or with nonzero payload");

	// A finished token is at least one byte long.
	a_term_weight: assert property (@(posedge clk) disable iff (!arst_n)
		valid && term_valid |-> token_weight != 16'd0)
		else $error("term with zero weight");

endmodule

bind token_hash_sparse_encoder tse_checker u_tse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (terms.valid),
	.ready        (terms.ready),
	.term_id      (terms.term_id),
	.token_weight (terms.token_weight),
	.term_valid   (terms.term_valid),
	.end_of_text  (terms.end_of_text)
);

[tb/token_hash_sparse_encoder_test.sv]
// Self-checking testbench for token_hash_sparse_encoder: streams text bytes, predicts
// the FNV-1a term ids and token weights, and compares every result transfer in order.
// Depends on tse_pkg, tse_if and the RTL of token_hash_sparse_encoder.
`timescale 1ns / 100ps

module token_hash_sparse_encoder_test;
	import tse_pkg::*;

	localparam int unsigned VOCAB_SIZE = VOCAB_SIZE_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CALM_ITEMS = 300;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic [TERM_ID_W-1:0] term_id;
		logic [WEIGHT_W-1:0]  token_weight;
		logic                 term_valid;
		logic                 end_of_text;
	} term_result_t;

	typedef struct {
		logic [7:0]   text_byte;
		logic         last_byte;
		bit           typed_in;
		term_result_t result;
	} text_row_t;

	logic clk;
	logic arst_n;
	bit sender_idle = 1'b0;
	bit receiver_idle = 1'b0;
	int fail_count = 0;

	logic [31:0]         hash_acc;
	logic [WEIGHT_W-1:0] token_len;
	bit                  in_token;
	term_result_t        pending_terms[$];

	tse_byte_if text_if();
	tse_term_if terms_if();

	token_hash_sparse_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if),
		.terms(terms_if)
	);

	// Letters and digit rows around every class boundary, and the text endings.
	text_row_t directed_rows [23] = '{
		'{8'h2E, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b1}},
		'{8'hFF, 1'b1, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b1}},
		'{"A", 1'b0, 1'b0, '0},
		'{"z", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"9", 1'b0, 1'b0, '0},
		'{"Z", 1'b0, 1'b0, '0},
		'{"a", 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{"Q", 1'b1, 1'b0, '0},
		'{"m", 1'b0, 1'b0, '0},
		'{8'h40, 1'b0, 1'b0, '0},
		'{8'h5B, 1'b0, 1'b0, '0},
		'{"b", 1'b0, 1'b0, '0},
		'{8'h60, 1'b0, 1'b0, '0},
		'{8'h7B, 1'b0, 1'b0, '0},
		'{8'h2F, 1'b0, 1'b0, '0},
		'{8'h3A, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b1, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b1}},
		'{"1", 1'b0, 1'b0, '0},
		'{8'h7B, 1'b1, 1'b0, '0},
		'{8'h20, 1'b0, 1'b0, '0}
	};

	function automatic void restart_token();
		hash_acc = FNV_BASIS;
		token_len = '0;
		in_token = 1'b0;
	endfunction

	function automatic term_result_t finished_term(input bit carries_term, input bit eot);
		term_result_t r;
		logic [31:0] remainder;
		r = '0;
		if (carries_term) begin
			remainder = hash_acc % VOCAB_SIZE;
			r.term_id = remainder[TERM_ID_W-1:0];
			r.token_weight = token_len;
			r.term_valid = 1'b1;
		end
		r.end_of_text = eot;
		return r;
	endfunction

	function automatic bit fold_text_byte(input logic [7:0] b, input logic last,
			output term_result_t r);
		logic [7:0] c;
		bit is_upper;
		bit is_word;
		is_upper = b >= CH_UPPER_A && b <= CH_UPPER_Z;
		is_word = is_upper || (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
			(b >= CH_LOWER_A && b <= CH_LOWER_Z);
		r = '0;
		if (is_word) begin
			c = is_upper ? b + CASE_OFFSET : b;
			if (!in_token) begin
				restart_token();
				in_token = 1'b1;
			end
			hash_acc = (hash_acc ^ {24'd0, c}) * FNV_PRIME;
			if (token_len != WEIGHT_MAX)
				token_len++;
			if (last) begin
				r = finished_term(1'b1, 1'b1);
				restart_token();
				return 1'b1;
			end
			return 1'b0;
		end
		if (in_token || last) begin
			r = finished_term(in_token, last);
			restart_token();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] random_word_char();
		case ($urandom_range(0, 2))
			0: begin
				return CH_DIGIT_0 + 8'($urandom_range(0, 9));
			end
			1: begin
				return CH_UPPER_A + 8'($urandom_range(0, 25));
			end
			default: begin
				return CH_LOWER_A + 8'($urandom_range(0, 25));
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed_in,
			input term_result_t typed_result);
		term_result_t r;
		if (sender_idle && $urandom_range(0, 7) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= b;
		text_if.last_byte <= last;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		if (fold_text_byte(b, last, r))
			pending_terms.push_back(typed_in ? typed_result : r);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		terms_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (receiver_idle && $urandom_range(0, 7) == 0) begin
				terms_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			terms_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		term_result_t want;
		if (arst_n && terms_if.valid && terms_if.ready) begin
			if (pending_terms.size() == 0) begin
				$error("unexpected term transfer: term_id %0d weight %0d term_valid %0b eot %0b",
					terms_if.term_id, terms_if.token_weight, terms_if.term_valid,
					terms_if.end_of_text);
				fail_count++;
			end else begin
				want = pending_terms.pop_front();
				if (terms_if.term_id !== want.term_id) begin
					$error("term_id: expected %0d, actual %0d", want.term_id, terms_if.term_id);
					fail_count++;
				end
				if (terms_if.token_weight !== want.token_weight) begin
					$error("token_weight: expected %0d, actual %0d", want.token_weight,
						terms_if.token_weight);
					fail_count++;
				end
				if (terms_if.term_valid !== want.term_valid) begin
					$error("term_valid: expected %0b, actual %0b", want.term_valid,
						terms_if.term_valid);
					fail_count++;
				end
				if (terms_if.end_of_text !== want.end_of_text) begin
					$error("end_of_text: expected %0b, actual %0b", want.end_of_text,
						terms_if.end_of_text);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [7:0] b;
		int long_len;
		arst_n <= 1'b0;
		text_if.valid <= 1'b0;
		text_if.text_byte <= '0;
		text_if.last_byte <= 1'b0;
		restart_token();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].text_byte, directed_rows[i].last_byte,
				directed_rows[i].typed_in, directed_rows[i].result);

		// One token longer than the weight can count, so the weight saturates.
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		long_len = 65535 + $urandom_range(1, 300);
		for (int i = 0; i < long_len; i++)
			send_byte(random_word_char(), 1'b0, 1'b0, '0);
		send_byte(8'($urandom_range(0, 47)), 1'($urandom_range(0, 1)), 1'b0, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0) begin
				sender_idle = $urandom_range(0, 3) != 0;
				receiver_idle = $urandom_range(0, 3) != 0;
			end
			if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
				sender_idle = 1'b0;
				receiver_idle = 1'b0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					b = random_word_char();
				end
				6, 7: begin
					b = 8'($urandom_range(0, 47));
				end
				8: begin
					b = 8'($urandom_range(128, 255));
				end
				default: begin
					b = 8'($urandom_range(0, 255));
				end
			endcase
			send_byte(b, $urandom_range(0, 19) == 0, 1'b0, '0);
		end
		text_if.valid <= 1'b0;

		while (pending_terms.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#16_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
